[rtl/s1k_pkg.sv]
// Shared types and constants for the SHA-1 keystream generator.
`default_nettype none
package s1k_pkg;

	localparam logic [159:0] SHA1_IV = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WAIT
	} s1k_state_t;

	typedef enum logic [2:0] {
		BK_DATA,
		BK_PAD_A,
		BK_PAD_B,
		BK_RB_A,
		BK_RB_B
	} blk_kind_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [6:0] rnd;
	} core_st_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// word i of a 160-bit digest, word 0 in the top bits
	function automatic logic [31:0] word_of(input logic [159:0] v, input logic [2:0] i);
		logic [4:0][31:0] vv;
		vv = v;
		return vv[3'd4 - i];
	endfunction

endpackage
`default_nettype wire

[rtl/s1k_round_core.sv]
// Iterative SHA-1 compression unit, one round per cycle.
`default_nettype none
module s1k_round_core import s1k_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [159:0] h_in,
	input  wire logic [31:0]  word_in,
	output core_st_t          st,
	output logic [159:0]      h_out
);
	logic         busy_q, done_q;
	logic [6:0]   rnd_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [159:0] base_q;
	logic [31:0]  w_q [16];
	logic [31:0]  w_t, f, k, t_sum;

	always_comb begin
		if (rnd_q < 7'd16) begin
			w_t = word_in;
		end else begin
			w_t = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
		end
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62C1D6;
		end
		t_sum = rotl(a_q, 5) + f + e_q + k + w_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'd79) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			base_q <= h_in;
			a_q <= h_in[159:128];
			b_q <= h_in[127:96];
			c_q <= h_in[95:64];
			d_q <= h_in[63:32];
			e_q <= h_in[31:0];
		end else if (busy_q) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_t;
		end
	end

	assign h_out = {base_q[159:128] + a_q, base_q[127:96] + b_q, base_q[95:64] + c_q,
		base_q[63:32] + d_q, base_q[31:0] + e_q};
	assign st = '{busy: busy_q, done: done_q, rnd: rnd_q};

endmodule
`default_nettype wire

[rtl/sha1_keystream_generator_top.sv]
// Top level: seed absorption, block sequencer and keystream byte output.
// A request beat with bytes left gives its byte in the cycle after acceptance.
// A rebuild (every 20th byte) runs two blocks; closing the second seed half adds
// padding blocks and a rebuild.
// Seed beats go in back to back unless a block fills, a half closes or output is stalled.
// Asynchronous active-low reset clears hashes, index and length; block buffer is not cleared.
`default_nettype none
module sha1_keystream_generator_top import s1k_pkg::*; #(
	parameter int MAX_HALF_BYTES = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // [7:0] seed_byte
	input  wire logic [1:0] s_tuser,  // [0] command, [1] seed_half
	input  wire logic       s_tlast,  // last_of_half
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata   // [7:0] out_byte
);
	s1k_state_t      state_q, state_d;
	blk_kind_t       kind_q;
	core_st_t        cst;
	logic            core_start, blk_done, more;
	logic [159:0]    h_out, core_h_in;
	logic [31:0]     word_in;
	logic [159:0]    first_q, second_q, cur_q, chain_q, tmp_q, middle;
	logic [4:0]      idx_q;
	logic [15:0]     hl_q;
	logic            last_q, half_q, req_q, mid_zero_q;
	logic [7:0]      out_q;
	logic            mv_q, mv_set;
	logic [3:0][7:0] mem [16];
	logic [3:0][7:0] rd_q;
	logic [3:0]      rd_addr;
	logic [5:0]      pos;
	logic [19:0][7:0] cur_bytes;
	logic            s_acc, fin;

	assign s_acc    = s_tvalid && s_tready;
	assign pos      = hl_q[5:0];
	assign middle   = mid_zero_q ? '0 : cur_q;
	assign blk_done = (state_q == ST_WAIT) && cst.done;
	assign cur_bytes = cur_q;
	assign fin = (kind_q == BK_PAD_B) || ((kind_q == BK_PAD_A) && (pos < 6'd56));
	// a new output beat is loaded either from a request or from a finished rebuild
	assign mv_set = (s_acc && s_tuser[0] && idx_q < 5'd20) ||
		(blk_done && kind_q == BK_RB_B && req_q);

	s1k_round_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.h_in   (core_h_in),
		.word_in(word_in),
		.st     (cst),
		.h_out  (h_out)
	);

	always_comb begin
		case (kind_q)
			BK_RB_A: core_h_in = SHA1_IV;
			BK_RB_B: core_h_in = tmp_q;
			default: core_h_in = chain_q;
		endcase
	end

	// block word for the current round
	always_comb begin
		logic [5:0] b;
		b = '0;
		word_in = '0;
		case (kind_q)
			BK_DATA: word_in = rd_q;
			BK_PAD_A: begin
				for (int j = 0; j < 4; j++) begin
					b = {cst.rnd[3:0], 2'(j)};
					if (b < pos) begin
						word_in[31-8*j -: 8] = rd_q[3-j];
					end else if (b == pos) begin
						word_in[31-8*j -: 8] = 8'h80;
					end
				end
				if (pos < 6'd56 && cst.rnd[3:0] == 4'd15) begin
					word_in = {13'd0, hl_q, 3'd0};
				end
			end
			BK_PAD_B: begin
				if (cst.rnd[3:0] == 4'd15) begin
					word_in = {13'd0, hl_q, 3'd0};
				end
			end
			BK_RB_A: begin
				if (cst.rnd < 7'd5) begin
					word_in = word_of(first_q, cst.rnd[2:0]);
				end else if (cst.rnd < 7'd10) begin
					word_in = word_of(middle, 3'(cst.rnd - 7'd5));
				end else if (cst.rnd < 7'd15) begin
					word_in = word_of(second_q, 3'(cst.rnd - 7'd10));
				end else begin
					word_in = 32'h80000000;
				end
			end
			BK_RB_B: begin
				if (cst.rnd[3:0] == 4'd15) begin
					word_in = 32'd480;
				end
			end
			default: word_in = '0;
		endcase
	end

	// another block follows the one just finished
	always_comb begin
		case (kind_q)
			BK_DATA:  more = last_q;
			BK_PAD_A: more = (pos >= 6'd56) || half_q;
			BK_PAD_B: more = half_q;
			BK_RB_A:  more = 1'b1;
			default:  more = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (s_tuser[0]) begin
						if (idx_q >= 5'd20) state_d = ST_LOAD;
					end else if ((hl_q < 16'(MAX_HALF_BYTES) && hl_q[5:0] == 6'd63) || s_tlast) begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: state_d = ST_WAIT;
			ST_WAIT: begin
				if (cst.done) state_d = more ? ST_LOAD : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		core_start = (state_q == ST_LOAD);
		s_tready   = (state_q == ST_IDLE) && (!mv_q || m_tready);
	end

	assign rd_addr = cst.busy ? cst.rnd[3:0] + 4'd1 : 4'd0;

	always_ff @(posedge clk) begin
		if (s_acc && !s_tuser[0] && hl_q < 16'(MAX_HALF_BYTES)) begin
			mem[hl_q[5:2]][2'd3 - hl_q[1:0]] <= s_tdata;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kind_q     <= BK_DATA;
			first_q    <= '0;
			second_q   <= '0;
			cur_q      <= '0;
			chain_q    <= SHA1_IV;
			tmp_q      <= '0;
			idx_q      <= '0;
			hl_q       <= '0;
			last_q     <= 1'b0;
			half_q     <= 1'b0;
			req_q      <= 1'b0;
			mid_zero_q <= 1'b0;
			out_q      <= '0;
			mv_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mv_set) mv_q <= 1'b1;
			else if (m_tready) mv_q <= 1'b0;
			if (s_acc) begin
				if (s_tuser[0]) begin
					if (idx_q >= 5'd20) begin
						req_q      <= 1'b1;
						mid_zero_q <= 1'b0;
						kind_q     <= BK_RB_A;
					end else begin
						out_q <= cur_bytes[5'd19 - idx_q];
						idx_q <= idx_q + 5'd1;
					end
				end else begin
					last_q <= s_tlast;
					half_q <= s_tuser[1];
					if (hl_q < 16'(MAX_HALF_BYTES)) hl_q <= hl_q + 16'd1;
					if (hl_q < 16'(MAX_HALF_BYTES) && hl_q[5:0] == 6'd63) begin
						kind_q <= BK_DATA;
					end else begin
						kind_q <= BK_PAD_A;
					end
				end
			end
			if (blk_done) begin
				case (kind_q)
					BK_DATA: begin
						chain_q <= h_out;
						kind_q  <= BK_PAD_A;
					end
					BK_PAD_A, BK_PAD_B: begin
						if (!fin) begin
							chain_q <= h_out;
							kind_q  <= BK_PAD_B;
						end else begin
							if (half_q) second_q <= h_out;
							else first_q <= h_out;
							chain_q    <= SHA1_IV;
							hl_q       <= '0;
							last_q     <= 1'b0;
							mid_zero_q <= 1'b1;
							kind_q     <= BK_RB_A;
						end
					end
					BK_RB_A: begin
						tmp_q  <= h_out;
						kind_q <= BK_RB_B;
					end
					BK_RB_B: begin
						cur_q <= h_out;
						idx_q <= req_q ? 5'd1 : 5'd0;
						if (req_q) begin
							out_q <= h_out[159:152];
							req_q <= 1'b0;
						end
					end
					default: kind_q <= BK_DATA;
				endcase
			end
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = out_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		core_start |-> !cst.busy) else $error("core started while busy");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 5'd20) else $error("byte index past digest");
	a_req_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser[0] && idx_q >= 5'd20) |=> (state_q == ST_LOAD && kind_q == BK_RB_A))
		else $error("exhausted digest did not start rebuild");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cst.done |-> state_q == ST_WAIT) else $error("block done outside wait");

endmodule
`default_nettype wire
